// ===== rtl/core/pmhe_pkg.sv =====
// Shared types and constants for the PS/2 mouse host engine.
// Holds the beat, result and register-file types used by every rtl/core file.
// No dependencies.
package pmhe_pkg;

	localparam int WAIT_BITS_DEF = 20;

	localparam int LONG_W = 16;
	localparam int SHORT_W = 16;
	localparam int TINY_W = 16;
	localparam int INIT_W = 20;

	localparam logic [LONG_W-1:0] LONG_RST = 16'd300;
	localparam logic [SHORT_W-1:0] SHORT_RST = 16'd50;
	localparam logic [TINY_W-1:0] TINY_RST = 16'd5;
	localparam logic [INIT_W-1:0] INIT_RST = 20'd100000;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_LONG = 2'd0;
	localparam logic [1:0] REG_SHORT = 2'd1;
	localparam logic [1:0] REG_TINY = 2'd2;
	localparam logic [1:0] REG_INIT = 2'd3;

	// command codes
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_SEND = 3'd1;
	localparam logic [2:0] OP_RECV = 3'd2;
	localparam logic [2:0] OP_INIT = 3'd3;
	localparam logic [2:0] OP_POLL = 3'd4;

	typedef struct packed {
		logic [LONG_W-1:0] long_wait_ticks;
		logic [SHORT_W-1:0] short_wait_ticks;
		logic [TINY_W-1:0] tiny_wait_ticks;
		logic [INIT_W-1:0] init_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] tx_byte;
		logic clk_line;
		logic data_line;
	} item_t;

	typedef struct packed {
		logic clk_pull_low;
		logic data_pull_low;
		logic busy_res;
		logic [7:0] rx_byte;
		logic rx_valid;
		logic [7:0] status_byte;
		logic [7:0] x_move;
		logic [7:0] y_move;
		logic poll_valid;
		logic done_res;
	} result_t;

endpackage

// ===== rtl/core/pmhe_regs.sv =====
// APB register file for the PS/2 mouse host engine wait lengths.
// Depends on pmhe_pkg for the register layout and reset values.
module pmhe_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output pmhe_pkg::cfg_t cfg
);

	logic [1:0] idx;
	logic wr_en;
	pmhe_pkg::cfg_t cfg_q;

	assign idx = paddr[3:2];
	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_wait_ticks <= pmhe_pkg::LONG_RST;
			cfg_q.short_wait_ticks <= pmhe_pkg::SHORT_RST;
			cfg_q.tiny_wait_ticks <= pmhe_pkg::TINY_RST;
			cfg_q.init_wait_ticks <= pmhe_pkg::INIT_RST;
		end else if (wr_en) begin
			case (idx)
				pmhe_pkg::REG_LONG: cfg_q.long_wait_ticks <= pwdata[pmhe_pkg::LONG_W-1:0];
				pmhe_pkg::REG_SHORT: cfg_q.short_wait_ticks <= pwdata[pmhe_pkg::SHORT_W-1:0];
				pmhe_pkg::REG_TINY: cfg_q.tiny_wait_ticks <= pwdata[pmhe_pkg::TINY_W-1:0];
				pmhe_pkg::REG_INIT: cfg_q.init_wait_ticks <= pwdata[pmhe_pkg::INIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			pmhe_pkg::REG_LONG: prdata = 32'(cfg_q.long_wait_ticks);
			pmhe_pkg::REG_SHORT: prdata = 32'(cfg_q.short_wait_ticks);
			pmhe_pkg::REG_TINY: prdata = 32'(cfg_q.tiny_wait_ticks);
			pmhe_pkg::REG_INIT: prdata = 32'(cfg_q.init_wait_ticks);
			default: prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/core/pmhe_core.sv =====
// PS/2 host sequencer: phase state, bit shifter, wait counter and poll bytes.
// Advances one tick per step strobe. Depends on pmhe_pkg.
module pmhe_core #(
	parameter int WAIT_COUNTER_BITS = pmhe_pkg::WAIT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  pmhe_pkg::item_t item,
	input  pmhe_pkg::cfg_t cfg,
	output pmhe_pkg::result_t res
);

	localparam logic [4:0] PH_IDLE = 5'd0;
	localparam logic [4:0] PH_W_REL = 5'd1;
	localparam logic [4:0] PH_W_CLKLO = 5'd2;
	localparam logic [4:0] PH_W_DATLO = 5'd3;
	localparam logic [4:0] PH_W_AWAIT = 5'd4;
	localparam logic [4:0] PH_W_BIT_HI = 5'd5;
	localparam logic [4:0] PH_W_BIT_LO = 5'd6;
	localparam logic [4:0] PH_W_STOP = 5'd7;
	localparam logic [4:0] PH_W_ACK_LO = 5'd8;
	localparam logic [4:0] PH_W_ACK_HI = 5'd9;
	localparam logic [4:0] PH_R_START = 5'd10;
	localparam logic [4:0] PH_R_ST_LO = 5'd11;
	localparam logic [4:0] PH_R_TINY = 5'd12;
	localparam logic [4:0] PH_R_ST_HI = 5'd13;
	localparam logic [4:0] PH_R_BIT_LO = 5'd14;
	localparam logic [4:0] PH_R_BIT_HI = 5'd15;
	localparam logic [4:0] PH_DELAY = 5'd16;

	localparam logic [1:0] ACT_END = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;
	localparam logic [1:0] ACT_DELAY = 2'd3;

	localparam int WB = WAIT_COUNTER_BITS;
	localparam logic [32:0] WMAX = (33'd1 << WB) - 33'd1;

	// action list of each command
	function automatic logic [1:0] act_kind(input logic [2:0] cmd, input logic [2:0] st);
		logic [1:0] k;
		k = ACT_END;
		case (cmd)
			pmhe_pkg::OP_SEND: if (st == 3'd0) k = ACT_WRITE;
			pmhe_pkg::OP_RECV: if (st == 3'd0) k = ACT_READ;
			pmhe_pkg::OP_INIT: begin
				case (st)
					3'd0, 3'd4: k = ACT_WRITE;
					3'd1, 3'd2, 3'd3, 3'd5: k = ACT_READ;
					3'd6: k = ACT_DELAY;
					default: k = ACT_END;
				endcase
			end
			pmhe_pkg::OP_POLL: begin
				case (st)
					3'd0: k = ACT_WRITE;
					3'd1, 3'd2, 3'd3, 3'd4: k = ACT_READ;
					default: k = ACT_END;
				endcase
			end
			default: k = ACT_END;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] act_byte(input logic [2:0] cmd, input logic [2:0] st);
		logic [7:0] b;
		b = 8'h00;
		if (cmd == pmhe_pkg::OP_INIT && st == 3'd0) b = 8'hff;
		else if (cmd == pmhe_pkg::OP_INIT && st == 3'd4) b = 8'hf0;
		else if (cmd == pmhe_pkg::OP_POLL && st == 3'd0) b = 8'heb;
		return b;
	endfunction

	// clamp a configured length to the counter range
	function automatic logic [WB-1:0] sat_wait(input logic [19:0] n);
		logic [32:0] ne;
		ne = 33'(n);
		return (ne > WMAX) ? WMAX[WB-1:0] : ne[WB-1:0];
	endfunction

	logic [4:0] phase_q, n_phase;
	logic [3:0] seq_q, n_seq;
	logic [2:0] cmd_q, n_cmd;
	logic [3:0] bit_q, n_bit;
	logic [7:0] shift_q, n_shift;
	logic par_q, n_par;
	logic [WB-1:0] wait_q, n_wait;
	logic chold_q, n_chold;
	logic dhold_q, n_dhold;
	logic [7:0] stat_q, n_stat;
	logic [7:0] x_q, n_x;
	logic [7:0] y_q, n_y;
	logic [7:0] rx_q, n_rx;
	logic p_rx, p_poll, p_done;

	always_comb begin
		logic begin_act;
		logic [7:0] tx_sel;
		logic [7:0] sh;
		logic tdone;
		logic [2:0] cmd_eff;
		logic [1:0] kind;
		logic [3:0] bc;

		n_phase = phase_q;
		n_seq = seq_q;
		n_cmd = cmd_q;
		n_bit = bit_q;
		n_shift = shift_q;
		n_par = par_q;
		n_wait = wait_q;
		n_chold = chold_q;
		n_dhold = dhold_q;
		n_stat = stat_q;
		n_x = x_q;
		n_y = y_q;
		n_rx = rx_q;
		p_rx = 1'b0;
		p_poll = 1'b0;
		p_done = 1'b0;
		begin_act = 1'b0;
		tx_sel = 8'h00;
		sh = 8'h00;
		bc = 4'd0;
		tdone = (wait_q == '0);
		if (!tdone) n_wait = wait_q - WB'(1);

		if (phase_q == PH_IDLE) begin
			n_wait = wait_q;
			if (item.op inside {[pmhe_pkg::OP_SEND:pmhe_pkg::OP_POLL]}) begin
				n_cmd = item.op;
				n_seq = 4'd0;
				if (item.op == pmhe_pkg::OP_INIT) begin
					n_chold = 1'b1;
					n_dhold = 1'b0;
				end
				begin_act = 1'b1;
				tx_sel = item.tx_byte;
			end
		end else begin
			// counter only runs in timed phases
			if (!(phase_q inside {PH_W_REL, PH_W_CLKLO, PH_W_DATLO, PH_W_STOP,
					PH_R_START, PH_R_TINY, PH_DELAY}))
				n_wait = wait_q;
			case (phase_q)
				PH_W_REL: if (tdone) begin
					n_chold = 1'b1;
					n_wait = sat_wait(20'(cfg.long_wait_ticks));
					n_phase = PH_W_CLKLO;
				end
				PH_W_CLKLO: if (tdone) begin
					n_dhold = 1'b1;
					n_wait = sat_wait(20'(cfg.long_wait_ticks));
					n_phase = PH_W_DATLO;
				end
				PH_W_DATLO: if (tdone) begin
					n_chold = 1'b0;
					n_phase = PH_W_AWAIT;
				end
				PH_W_AWAIT: if (!item.clk_line) begin
					n_bit = 4'd0;
					n_dhold = ~shift_q[0];
					n_phase = PH_W_BIT_HI;
				end
				PH_W_BIT_HI: if (item.clk_line) n_phase = PH_W_BIT_LO;
				PH_W_BIT_LO: if (!item.clk_line) begin
					if (bit_q < 4'd8) begin
						n_par = par_q ^ shift_q[0];
						sh = {1'b0, shift_q[7:1]};
						n_shift = sh;
						bc = bit_q + 4'd1;
						n_bit = bc;
						n_dhold = (bc < 4'd8) ? ~sh[0] : ~(par_q ^ shift_q[0]);
						n_phase = PH_W_BIT_HI;
					end else begin
						n_dhold = 1'b0;
						n_wait = sat_wait(20'(cfg.short_wait_ticks));
						n_phase = PH_W_STOP;
					end
				end
				PH_W_STOP: if (tdone) n_phase = PH_W_ACK_LO;
				PH_W_ACK_LO: if (!item.clk_line) n_phase = PH_W_ACK_HI;
				PH_W_ACK_HI: if (item.clk_line) begin
					n_chold = 1'b1;
					n_seq = seq_q + 4'd1;
					begin_act = 1'b1;
				end
				PH_R_START: if (tdone) n_phase = PH_R_ST_LO;
				PH_R_ST_LO: if (!item.clk_line) begin
					n_wait = sat_wait(20'(cfg.tiny_wait_ticks));
					n_phase = PH_R_TINY;
				end
				PH_R_TINY: if (tdone) n_phase = PH_R_ST_HI;
				PH_R_ST_HI: if (item.clk_line) begin
					n_bit = 4'd0;
					n_shift = 8'h00;
					n_phase = PH_R_BIT_LO;
				end
				PH_R_BIT_LO: if (!item.clk_line) begin
					if (bit_q < 4'd8 && item.data_line) n_shift[bit_q[2:0]] = 1'b1;
					n_phase = PH_R_BIT_HI;
				end
				PH_R_BIT_HI: if (item.clk_line) begin
					bc = bit_q + 4'd1;
					n_bit = bc;
					if (bc >= 4'd10) begin
						// byte done: hold the clock and file it by poll step
						n_chold = 1'b1;
						n_rx = shift_q;
						if (cmd_q == pmhe_pkg::OP_POLL) begin
							if (seq_q == 4'd2) n_stat = shift_q;
							else if (seq_q == 4'd3) n_x = shift_q;
							else if (seq_q == 4'd4) n_y = shift_q;
						end
						n_seq = seq_q + 4'd1;
						begin_act = 1'b1;
					end else begin
						n_phase = PH_R_BIT_LO;
					end
				end
				PH_DELAY: if (tdone) begin
					n_seq = seq_q + 4'd1;
					begin_act = 1'b1;
				end
				default: n_phase = PH_IDLE;
			endcase
		end

		// start the action at the current step of the command
		cmd_eff = (n_cmd <= pmhe_pkg::OP_POLL) ? n_cmd : pmhe_pkg::OP_NONE;
		kind = act_kind(cmd_eff, n_seq[2:0]);
		if (begin_act) begin
			case (kind)
				ACT_WRITE: begin
					n_shift = (cmd_eff == pmhe_pkg::OP_SEND) ? tx_sel
						: act_byte(cmd_eff, n_seq[2:0]);
					n_par = 1'b1;
					n_bit = 4'd0;
					n_chold = 1'b0;
					n_dhold = 1'b0;
					n_wait = sat_wait(20'(cfg.long_wait_ticks));
					n_phase = PH_W_REL;
				end
				ACT_READ: begin
					n_chold = 1'b0;
					n_dhold = 1'b0;
					n_wait = sat_wait(20'(cfg.short_wait_ticks));
					n_phase = PH_R_START;
				end
				ACT_DELAY: begin
					n_wait = sat_wait(cfg.init_wait_ticks);
					n_phase = PH_DELAY;
				end
				default: begin
					n_phase = PH_IDLE;
					p_done = 1'b1;
					p_rx = (cmd_eff == pmhe_pkg::OP_RECV);
					p_poll = (cmd_eff == pmhe_pkg::OP_POLL);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			seq_q <= 4'd0;
			cmd_q <= pmhe_pkg::OP_NONE;
			bit_q <= 4'd0;
			shift_q <= 8'h00;
			par_q <= 1'b1;
			wait_q <= '0;
			chold_q <= 1'b1;
			dhold_q <= 1'b0;
			stat_q <= 8'h00;
			x_q <= 8'h00;
			y_q <= 8'h00;
			rx_q <= 8'h00;
		end else if (step) begin
			phase_q <= n_phase;
			seq_q <= n_seq;
			cmd_q <= n_cmd;
			bit_q <= n_bit;
			shift_q <= n_shift;
			par_q <= n_par;
			wait_q <= n_wait;
			chold_q <= n_chold;
			dhold_q <= n_dhold;
			stat_q <= n_stat;
			x_q <= n_x;
			y_q <= n_y;
			rx_q <= n_rx;
		end
	end

	always_comb begin
		res.clk_pull_low = n_chold;
		res.data_pull_low = n_dhold;
		res.busy_res = (n_phase != PH_IDLE);
		res.rx_byte = n_rx;
		res.rx_valid = p_rx;
		res.status_byte = n_stat;
		res.x_move = n_x;
		res.y_move = n_y;
		res.poll_valid = p_poll;
		res.done_res = p_done;
	end

endmodule

// ===== rtl/core/ps2_mouse_host_engine.sv =====
// Top level of the PS/2 mouse host engine: input register, output register, APB port.
// Instantiates pmhe_regs and pmhe_core; depends on pmhe_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  s_*      | s_tvalid / s_tready    | one line sample per tick plus command
//  m_*      | m_tvalid / m_tready    | line drive requests, status, poll bytes
//  APB      | psel/penable/pready    | wait-length registers at 0x0..0xC
//
// One beat per cycle sustained while the output is not stalled: an input beat is
// registered, the sequencer steps on it and the result lands in the output register.
// A stalled output holds the pipeline without dropping beats; the input register
// still takes one beat while the output waits. Reset clears the sequencer to idle
// with the clock line held low and registers at defaults.
module ps2_mouse_host_engine #(
	parameter int WAIT_COUNTER_BITS = pmhe_pkg::WAIT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [15:0] s_tdata,   // tx_byte[7:0], clk_line[8], data_line[9], zero[15:10]
	input  logic [2:0] s_tuser,    // op[2:0]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [39:0] m_tdata,   // clk_pull_low[0], data_pull_low[1], busy_res[2],
	                               // rx_byte[10:3], rx_valid[11], status_byte[19:12],
	                               // x_move[27:20], y_move[35:28], poll_valid[36],
	                               // done_res[37], zero[39:38]
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	pmhe_pkg::cfg_t cfg;
	pmhe_pkg::item_t item_s1;
	pmhe_pkg::result_t res;
	pmhe_pkg::result_t out_q;
	logic valid_s1;
	logic out_valid_q;
	logic fire;
	logic out_free;

	pmhe_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign out_free = !out_valid_q || m_tready;
	assign fire = valid_s1 && out_free;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op <= s_tuser;
			item_s1.tx_byte <= s_tdata[7:0];
			item_s1.clk_line <= s_tdata[8];
			item_s1.data_line <= s_tdata[9];
		end
	end

	pmhe_core #(
		.WAIT_COUNTER_BITS(WAIT_COUNTER_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(fire),
		.item(item_s1),
		.cfg(cfg),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {2'b00, out_q.done_res, out_q.poll_valid, out_q.y_move, out_q.x_move,
		out_q.status_byte, out_q.rx_valid, out_q.rx_byte, out_q.busy_res,
		out_q.data_pull_low, out_q.clk_pull_low};

endmodule
